>>> design/abr_pkg.sv
package abr_pkg;

    localparam int SUM_W      = 20;
    localparam int CNT_W      = 8;
    localparam int CFG_W      = 8;
    localparam int VREF_W     = 11;
    localparam int OUT_W      = 24;
    localparam int IN_FIELDS  = 5;
    localparam int VAL_FIELDS = 4;
    localparam int VIW        = $clog2(VAL_FIELDS);
    localparam int KW         = 3;
    localparam int RAT_W      = 31;
    localparam int DIV_W      = 40;
    localparam int DVS_W      = 20;
    localparam int Q_DEPTH    = 2;
    localparam int APB_W      = 32;
    localparam int ADDR_W     = 5;
    localparam int IDX_W      = ADDR_W - 2;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    typedef logic [IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_BATCH = 3'd0;
    localparam reg_idx_t REG_VREF  = 3'd1;
    localparam reg_idx_t REG_CDIV  = 3'd2;
    localparam reg_idx_t REG_VMULT = 3'd3;
    localparam reg_idx_t REG_VDIV  = 3'd4;

    localparam logic [CNT_W-1:0]  BATCH_RST = 8'd25;
    localparam logic [VREF_W-1:0] VREF_RST  = 11'd1205;
    localparam logic [CFG_W-1:0]  CDIV_RST  = 8'd5;
    localparam logic [CFG_W-1:0]  VMULT_RST = 8'd13;
    localparam logic [CFG_W-1:0]  VDIV_RST  = 8'd3;

    typedef struct packed {
        logic [CNT_W-1:0]  batch_size;
        logic [VREF_W-1:0] vref_mv;
        logic [CFG_W-1:0]  current_divisor;
        logic [CFG_W-1:0]  voltage_mult;
        logic [CFG_W-1:0]  voltage_div;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_sts_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

>>> design/adc_batch_average_ratiometric.sv
// Batch averager for ADC scans with ratiometric reference correction.
// Input channel: one beat per scan (ref_sample and chan_one..chan_four) on
// in_valid/in_stall. Scans are summed one per cycle while in_stall is low; a
// beat that arrives once the scan count has reached batch_size closes the batch
// and starts the next. Closed batches go into a two-entry queue; the back end
// works them through a shared radix-2 divider (thirteen divisions per batch, or
// only the channel-mean divisions when the reference mean is zero). in_stall
// rises only while the queue is full.
// Output channel: one beat per batch on out_valid/out_stall from a registered
// output stage; a stalled beat holds, and the back end may finish the next
// batch behind it and wait. ref_zero flags a zero reference mean, with all
// four values saturated.
// Registers via APB at 4*i: batch_size, vref_mv, current_divisor,
// voltage_mult, voltage_div. Write them only while idle.
// Reset clears the sums, scan count and queue and loads the default register
// values; there is no clearing pass.
module adc_batch_average_ratiometric
    import abr_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int CHANNELS    = 5
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [APB_W-1:0]       pwdata,
    output logic [APB_W-1:0]       prdata,
    output logic                   pready,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] ref_sample,
    input  logic [SAMPLE_BITS-1:0] chan_one,
    input  logic [SAMPLE_BITS-1:0] chan_two,
    input  logic [SAMPLE_BITS-1:0] chan_three,
    input  logic [SAMPLE_BITS-1:0] chan_four,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [OUT_W-1:0]       current_one,
    output logic [OUT_W-1:0]       current_two,
    output logic [OUT_W-1:0]       current_three,
    output logic [OUT_W-1:0]       supply_voltage,
    output logic                   ref_zero
);

    localparam int USED = (CHANNELS < IN_FIELDS) ? CHANNELS : IN_FIELDS;

    logic [CNT_W-1:0]  batch_reg;
    logic [VREF_W-1:0] vref_reg;
    logic [CFG_W-1:0]  cdiv_reg;
    logic [CFG_W-1:0]  vmult_reg;
    logic [CFG_W-1:0]  vdiv_reg;
    cfg_t              cfg;
    reg_idx_t          idx;
    logic              wr_en;

    logic [IN_FIELDS-1:0][SAMPLE_BITS-1:0] samples;
    q_sts_t                          q_sts;
    logic                            push;
    logic                            pop;
    logic [USED-1:0][SUM_W-1:0]      push_sums;
    logic [CNT_W-1:0]                push_cnt;
    logic [USED-1:0][SUM_W-1:0]      head_sums;
    logic [CNT_W-1:0]                head_cnt;
    logic [VAL_FIELDS-1:0][OUT_W-1:0] out_vals;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_reg <= BATCH_RST;
            vref_reg  <= VREF_RST;
            cdiv_reg  <= CDIV_RST;
            vmult_reg <= VMULT_RST;
            vdiv_reg  <= VDIV_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_BATCH: batch_reg <= pwdata[CNT_W-1:0];
                REG_VREF:  vref_reg  <= pwdata[VREF_W-1:0];
                REG_CDIV:  cdiv_reg  <= pwdata[CFG_W-1:0];
                REG_VMULT: vmult_reg <= pwdata[CFG_W-1:0];
                REG_VDIV:  vdiv_reg  <= pwdata[CFG_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BATCH: prdata = {{(APB_W-CNT_W){1'b0}}, batch_reg};
            REG_VREF:  prdata = {{(APB_W-VREF_W){1'b0}}, vref_reg};
            REG_CDIV:  prdata = {{(APB_W-CFG_W){1'b0}}, cdiv_reg};
            REG_VMULT: prdata = {{(APB_W-CFG_W){1'b0}}, vmult_reg};
            REG_VDIV:  prdata = {{(APB_W-CFG_W){1'b0}}, vdiv_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg.batch_size      = batch_reg;
    assign cfg.vref_mv         = vref_reg;
    assign cfg.current_divisor = cdiv_reg;
    assign cfg.voltage_mult    = vmult_reg;
    assign cfg.voltage_div     = vdiv_reg;

    assign samples = {chan_four, chan_three, chan_two, chan_one, ref_sample};

    abr_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CHANNELS    (CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .samples    (samples),
        .batch_size (cfg.batch_size),
        .q_sts      (q_sts),
        .push       (push),
        .push_sums  (push_sums),
        .push_cnt   (push_cnt)
    );

    abr_queue #(
        .CHANNELS (CHANNELS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_sums (push_sums),
        .push_cnt  (push_cnt),
        .pop       (pop),
        .head_sums (head_sums),
        .head_cnt  (head_cnt),
        .sts       (q_sts)
    );

    abr_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_sts     (q_sts),
        .head_sums (head_sums),
        .head_cnt  (head_cnt),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_vals  (out_vals),
        .out_zero  (ref_zero)
    );

    assign current_one    = out_vals[0];
    assign current_two    = out_vals[1];
    assign current_three  = out_vals[2];
    assign supply_voltage = out_vals[3];

endmodule

>>> design/abr_div.sv
module abr_div
    import abr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output div_sts_t         sts
);

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W:0]   rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W+1:0] diff;
    logic             ge;

    // restoring division, one quotient bit per cycle; a zero divisor gives all ones
    assign rem_sh = {rem_reg[DVS_W-1:0], quo_reg[DIV_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign ge     = ~diff[DVS_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W:0] : rem_sh;
        end
    end

    assign quotient = quo_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

>>> design/abr_queue.sv
module abr_queue
    import abr_pkg::*;
#(
    parameter int CHANNELS = 5,
    localparam int USED = (CHANNELS < IN_FIELDS) ? CHANNELS : IN_FIELDS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [USED-1:0][SUM_W-1:0]     push_sums,
    input  logic [CNT_W-1:0]               push_cnt,
    input  logic                           pop,
    output logic [USED-1:0][SUM_W-1:0]     head_sums,
    output logic [CNT_W-1:0]               head_cnt,
    output q_sts_t                         sts
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int FW = $clog2(Q_DEPTH + 1);

    logic [USED-1:0][SUM_W-1:0] ent_sums_reg [Q_DEPTH];
    logic [CNT_W-1:0]           ent_cnt_reg  [Q_DEPTH];
    logic [PW-1:0]              wr_ptr_reg;
    logic [PW-1:0]              rd_ptr_reg;
    logic [FW-1:0]              fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_sums_reg[wr_ptr_reg] <= push_sums;
            ent_cnt_reg[wr_ptr_reg]  <= push_cnt;
        end
    end

    assign head_sums = ent_sums_reg[rd_ptr_reg];
    assign head_cnt  = ent_cnt_reg[rd_ptr_reg];
    assign sts.full  = (fill_reg == FW'(Q_DEPTH));
    assign sts.valid = (fill_reg != '0);

endmodule

>>> design/abr_front.sv
module abr_front
    import abr_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int CHANNELS    = 5,
    localparam int USED = (CHANNELS < IN_FIELDS) ? CHANNELS : IN_FIELDS
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [IN_FIELDS-1:0][SAMPLE_BITS-1:0] samples,
    input  logic [CNT_W-1:0]                     batch_size,
    input  q_sts_t                               q_sts,
    output logic                                 push,
    output logic [USED-1:0][SUM_W-1:0]           push_sums,
    output logic [CNT_W-1:0]                     push_cnt
);

    logic [USED-1:0][SUM_W-1:0] sums_reg;
    logic [USED-1:0][SUM_W-1:0] sums_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic [CNT_W-1:0]           limit;
    logic                       accept;
    logic                       close;

    assign in_stall = q_sts.full;
    assign accept   = in_valid && !q_sts.full;
    assign limit    = (batch_size == '0) ? CNT_W'(1) : batch_size;
    assign close    = (cnt_reg >= limit);
    assign push     = accept && close;

    assign push_sums = sums_reg;
    assign push_cnt  = cnt_reg;

    always_comb
    begin
        for (int c = 0; c < USED; c++)
        begin
            sums_next[c] = (close ? '0 : sums_reg[c])
                         + {{(SUM_W-SAMPLE_BITS){1'b0}}, samples[c]};
        end
        cnt_next = close ? CNT_W'(1) : cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (accept)
        begin
            sums_reg <= sums_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

>>> design/abr_back.sv
module abr_back
    import abr_pkg::*;
#(
    parameter int CHANNELS = 5,
    localparam int USED = (CHANNELS < IN_FIELDS) ? CHANNELS : IN_FIELDS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cfg_t                            cfg,
    input  q_sts_t                          q_sts,
    input  logic [USED-1:0][SUM_W-1:0]      head_sums,
    input  logic [CNT_W-1:0]                head_cnt,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [VAL_FIELDS-1:0][OUT_W-1:0] out_vals,
    output logic                            out_zero
);

    localparam int CIW = $clog2(USED);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LAUNCH = 6'b000010,
        S_WAIT   = 6'b000100,
        S_CHECK  = 6'b001000,
        S_MUL    = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        PH_MEAN  = 3'b001,
        PH_SCALE = 3'b010,
        PH_POST  = 3'b100
    } phase_t;

    state_t                         state_reg, state_next;
    phase_t                         phase_reg, phase_next;
    logic [KW-1:0]                  k_reg, k_next;
    logic [USED-1:0][SUM_W-1:0]     sums_w_reg, sums_w_next;
    logic [CNT_W-1:0]               cnt_w_reg, cnt_w_next;
    logic [IN_FIELDS-1:0][SUM_W-1:0] mean_reg, mean_next;
    logic [DIV_W-1:0]               prod_reg, prod_next;
    logic [RAT_W-1:0]               ratio_reg, ratio_next;
    logic [VAL_FIELDS-1:0][OUT_W-1:0] val_reg, val_next;
    logic                           zero_reg, zero_next;
    logic                           out_valid_reg;
    logic [VAL_FIELDS-1:0][OUT_W-1:0] out_vals_reg;
    logic                           out_zero_reg;

    logic                           out_free;
    logic [KW-1:0]                  km1;
    logic [RAT_W-1:0]               mul_a;
    logic [VREF_W-1:0]              mul_b;
    logic [RAT_W+VREF_W-1:0]        prod;
    logic                           div_start;
    logic [DIV_W-1:0]               div_a;
    logic [DVS_W-1:0]               div_b;
    logic [DIV_W-1:0]               quo;
    div_sts_t                       div_sts;
    logic [OUT_W-1:0]               quo_sat;

    abr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (quo),
        .sts      (div_sts)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign km1       = k_reg - 1'b1;
    assign div_start = (state_reg == S_LAUNCH);
    assign quo_sat   = (|quo[DIV_W-1:OUT_W]) ? OUT_MAX : quo[OUT_W-1:0];
    assign prod      = mul_a * mul_b;

    always_comb
    begin
        if (phase_reg == PH_SCALE)
        begin
            mul_a = {{(RAT_W-SUM_W){1'b0}}, mean_reg[k_reg]};
            mul_b = cfg.vref_mv;
        end
        else
        begin
            mul_a = ratio_reg;
            mul_b = {{(VREF_W-CFG_W){1'b0}}, cfg.voltage_mult};
        end
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_MEAN:
            begin
                div_a = {{(DIV_W-SUM_W){1'b0}}, sums_w_reg[k_reg[CIW-1:0]]};
                div_b = {{(DVS_W-CNT_W){1'b0}}, cnt_w_reg};
            end
            PH_SCALE:
            begin
                div_a = prod_reg;
                div_b = mean_reg[0];
            end
            PH_POST:
            begin
                if (k_reg == KW'(VAL_FIELDS))
                begin
                    div_a = prod_reg;
                    div_b = {{(DVS_W-CFG_W){1'b0}}, cfg.voltage_div};
                end
                else
                begin
                    div_a = {{(DIV_W-RAT_W){1'b0}}, ratio_reg};
                    div_b = {{(DVS_W-CFG_W){1'b0}}, cfg.current_divisor};
                end
            end
            default:
            begin
                div_a = '0;
                div_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        k_next      = k_reg;
        sums_w_next = sums_w_reg;
        cnt_w_next  = cnt_w_reg;
        mean_next   = mean_reg;
        prod_next   = prod_reg;
        ratio_next  = ratio_reg;
        val_next    = val_reg;
        zero_next   = zero_reg;
        pop         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_sts.valid)
                begin
                    pop         = 1'b1;
                    sums_w_next = head_sums;
                    cnt_w_next  = head_cnt;
                    mean_next   = '0;
                    k_next      = '0;
                    phase_next  = PH_MEAN;
                    state_next  = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_sts.done)
                begin
                    unique case (phase_reg)
                        PH_MEAN:
                        begin
                            mean_next[k_reg] = quo[SUM_W-1:0];
                            if (k_reg == KW'(USED - 1))
                            begin
                                state_next = S_CHECK;
                            end
                            else
                            begin
                                k_next     = k_reg + 1'b1;
                                state_next = S_LAUNCH;
                            end
                        end
                        PH_SCALE:
                        begin
                            ratio_next = quo[RAT_W-1:0];
                            phase_next = PH_POST;
                            state_next = (k_reg == KW'(VAL_FIELDS)) ? S_MUL : S_LAUNCH;
                        end
                        PH_POST:
                        begin
                            val_next[km1[VIW-1:0]] = quo_sat;
                            if (k_reg == KW'(VAL_FIELDS))
                            begin
                                zero_next  = 1'b0;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                k_next     = k_reg + 1'b1;
                                phase_next = PH_SCALE;
                                state_next = S_MUL;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (mean_reg[0] == '0)
                begin
                    val_next   = {VAL_FIELDS{OUT_MAX}};
                    zero_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = KW'(1);
                    phase_next = PH_SCALE;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = prod[DIV_W-1:0];
                state_next = S_LAUNCH;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_MEAN;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sums_w_reg <= sums_w_next;
        cnt_w_reg  <= cnt_w_next;
        mean_reg   <= mean_next;
        prod_reg   <= prod_next;
        ratio_reg  <= ratio_next;
        val_reg    <= val_next;
        zero_reg   <= zero_next;
        if ((state_reg == S_DONE) && out_free)
        begin
            out_vals_reg <= val_reg;
            out_zero_reg <= zero_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vals  = out_vals_reg;
    assign out_zero  = out_zero_reg;

endmodule

>>> design/abr_chk.sv
module abr_chk
    import abr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic             ref_zero,
    input logic [OUT_W-1:0] current_one,
    input logic [OUT_W-1:0] current_two,
    input logic [OUT_W-1:0] current_three,
    input logic [OUT_W-1:0] supply_voltage
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ref_zero |-> current_one == OUT_MAX && current_two == OUT_MAX
            && current_three == OUT_MAX && supply_voltage == OUT_MAX)
        else $error("zero reference without saturated values");

    a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stall rose without an accepted beat");

endmodule

bind adc_batch_average_ratiometric abr_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ref_zero       (ref_zero),
    .current_one    (current_one),
    .current_two    (current_two),
    .current_three  (current_three),
    .supply_voltage (supply_voltage)
);
